// ===== rtl/usbchp_pkg.sv =====
package usbchp_pkg;

    // Fixed base header layout
    localparam int unsigned BASE_HEADER_BYTES = 27;
    localparam int unsigned HDR_IDX_W         = $clog2(BASE_HEADER_BYTES);
    localparam logic [31:0] COUNT_MAX          = 32'hFFFF_FFFF;
    localparam logic [7:0]  INFO_RESERVED_MASK = 8'hFE;

    // Record queue depth between the byte front end and the check back end
    localparam int unsigned QUEUE_DEPTH = 2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_SHORT         = 3'd1,
        ST_RESERVED      = 3'd2,
        ST_BAD_HDR_LEN   = 3'd3,
        ST_TRUNCATED     = 3'd4,
        ST_TRAILING      = 3'd5,
        ST_ORIG_MISMATCH = 3'd6
    } t_status;

    // One finished record, handed from the front end to the back end
    typedef struct packed {
        logic [BASE_HEADER_BYTES-1:0][7:0] hdr;
        logic [31:0]                       size;
        logic                              has_orig;
        logic [31:0]                       orig;
    } t_rec;

endpackage

// ===== rtl/usbchp_front.sv =====
module usbchp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last,
    input  logic               i_has_original_length,
    input  logic [31:0]        i_original_length,
    output logic               o_push_valid,
    output usbchp_pkg::t_rec   o_push_rec,
    input  logic               i_push_ready
);
    import usbchp_pkg::*;

    logic [31:0]                       r_count;
    logic [31:0]                       n_count;
    logic [BASE_HEADER_BYTES-1:0][7:0] r_hdr;
    logic [BASE_HEADER_BYTES-1:0][7:0] n_hdr;
    logic [31:0]                       count_inc;
    logic                              in_fire;
    logic                              in_hdr;
    logic [HDR_IDX_W-1:0]              hdr_idx;

    // Stall only when the record queue cannot take another record
    assign o_in_ready = i_push_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Saturating byte counter
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 32'd1;
    assign in_hdr    = r_count < 32'(BASE_HEADER_BYTES);
    assign hdr_idx   = r_count[HDR_IDX_W-1:0];

    // Drop the current byte into its header lane
    always_comb begin
        n_hdr = r_hdr;
        if (in_hdr) begin
            n_hdr[hdr_idx] = i_data_byte;
        end
        n_count = r_count;
        if (in_fire) begin
            n_count = i_last ? 32'd0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 32'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Header bytes need no reset: a record too short to fill them is zeroed later
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hdr <= n_hdr;
        end
    end

    // Hand the finished record to the queue on its last byte
    assign o_push_valid        = in_fire && i_last;
    assign o_push_rec.hdr      = n_hdr;
    assign o_push_rec.size     = count_inc;
    assign o_push_rec.has_orig = i_has_original_length;
    assign o_push_rec.orig     = i_original_length;

endmodule

// ===== rtl/usbchp_queue.sv =====
module usbchp_queue #(
    parameter int unsigned DEPTH = usbchp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  usbchp_pkg::t_rec i_push_rec,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output usbchp_pkg::t_rec o_pop_rec
);
    import usbchp_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_used;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_used;
    logic             push;
    logic             pop;

    assign o_push_ready = r_used != CNT_W'(DEPTH);
    assign o_pop_valid  = r_used != '0;
    assign o_pop_rec    = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_used   = r_used;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        priority case ({push, pop})
            2'b10:   n_used = r_used + CNT_W'(1);
            2'b01:   n_used = r_used - CNT_W'(1);
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_used   <= n_used;
        end
    end

    // Record storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

endmodule

// ===== rtl/usbchp_back.sv =====
module usbchp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  usbchp_pkg::t_rec i_pop_rec,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_hdr_len,
    output logic [63:0]      o_irp_id,
    output logic [31:0]      o_usbd_status,
    output logic [15:0]      o_function_code,
    output logic             o_direction_info,
    output logic [15:0]      o_bus_number,
    output logic [15:0]      o_device_address,
    output logic [7:0]       o_endpoint_number,
    output logic [7:0]       o_transfer_type,
    output logic [31:0]      o_data_length,
    output logic             o_payload_clipped
);
    import usbchp_pkg::*;

    // Stage 1 registers: record plus the size-based compares
    logic        r_s1_valid;
    t_rec        r_s1_rec;
    logic        r_s1_short;
    logic        r_s1_rsv;
    logic        r_s1_bad_hl;
    logic        r_s1_orig_gt;
    logic        r_s1_orig_ne;
    logic [31:0] r_s1_captured;
    logic [32:0] r_s1_expected;

    // Output registers
    logic        r_out_valid;
    t_status     r_status;
    logic [15:0] r_hdr_len;
    logic [63:0] r_irp_id;
    logic [31:0] r_usbd_status;
    logic [15:0] r_function_code;
    logic        r_direction_info;
    logic [15:0] r_bus_number;
    logic [15:0] r_device_address;
    logic [7:0]  r_endpoint_number;
    logic [7:0]  r_transfer_type;
    logic [31:0] r_data_length;
    logic        r_trunc;

    logic        out_en;
    logic        s1_en;
    logic [15:0] in_hl;
    logic [31:0] in_dlen;
    logic [7:0]  in_info;
    logic [15:0] s1_hl;
    logic [31:0] s1_dlen;
    t_status     n_status;
    logic        n_trunc;

    // Pipeline advance
    assign out_en      = !r_out_valid || i_out_ready;
    assign s1_en       = !r_s1_valid || out_en;
    assign o_pop_ready = s1_en;

    // Field views of the incoming record
    assign in_hl   = i_pop_rec.hdr[1:0];
    assign in_dlen = i_pop_rec.hdr[26:23];
    assign in_info = i_pop_rec.hdr[16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_pop_valid;
        end
    end

    // Stage 1: length arithmetic and compares against the record size
    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_rec      <= i_pop_rec;
            r_s1_short    <= i_pop_rec.size < 32'(BASE_HEADER_BYTES);
            r_s1_rsv      <= (in_info & INFO_RESERVED_MASK) != 8'd0;
            r_s1_bad_hl   <= (in_hl < 16'(BASE_HEADER_BYTES))
                             || ({16'd0, in_hl} > i_pop_rec.size);
            r_s1_orig_gt  <= i_pop_rec.orig > i_pop_rec.size;
            r_s1_orig_ne  <= i_pop_rec.orig != i_pop_rec.size;
            r_s1_captured <= i_pop_rec.size - {16'd0, in_hl};
            r_s1_expected <= {17'd0, in_hl} + {1'b0, in_dlen};
        end
    end

    assign s1_hl   = r_s1_rec.hdr[1:0];
    assign s1_dlen = r_s1_rec.hdr[26:23];

    // Stage 2: status in check order
    always_comb begin
        n_trunc = 1'b0;
        if (r_s1_short) begin
            n_status = ST_SHORT;
        end else if (r_s1_rsv) begin
            n_status = ST_RESERVED;
        end else if (r_s1_bad_hl) begin
            n_status = ST_BAD_HDR_LEN;
        end else if (s1_dlen > r_s1_captured) begin
            // Clipped payload is fine only when the original length confirms it
            if (r_s1_rec.has_orig && ({1'b0, r_s1_rec.orig} == r_s1_expected)
                    && r_s1_orig_gt) begin
                n_status = ST_OK;
                n_trunc  = 1'b1;
            end else begin
                n_status = ST_TRUNCATED;
            end
        end else if (s1_dlen != r_s1_captured) begin
            n_status = ST_TRAILING;
        end else if (r_s1_rec.has_orig && r_s1_orig_ne) begin
            n_status = ST_ORIG_MISMATCH;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Output register; a short record reports all-zero fields
    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_status <= n_status;
            r_trunc  <= n_trunc;
            if (r_s1_short) begin
                r_hdr_len         <= '0;
                r_irp_id          <= '0;
                r_usbd_status     <= '0;
                r_function_code   <= '0;
                r_direction_info  <= 1'b0;
                r_bus_number      <= '0;
                r_device_address  <= '0;
                r_endpoint_number <= '0;
                r_transfer_type   <= '0;
                r_data_length     <= '0;
            end else begin
                r_hdr_len         <= s1_hl;
                r_irp_id          <= r_s1_rec.hdr[9:2];
                r_usbd_status     <= r_s1_rec.hdr[13:10];
                r_function_code   <= r_s1_rec.hdr[15:14];
                r_direction_info  <= r_s1_rec.hdr[16][0];
                r_bus_number      <= r_s1_rec.hdr[18:17];
                r_device_address  <= r_s1_rec.hdr[20:19];
                r_endpoint_number <= r_s1_rec.hdr[21];
                r_transfer_type   <= r_s1_rec.hdr[22];
                r_data_length     <= s1_dlen;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_hdr_len           = r_hdr_len;
    assign o_irp_id            = r_irp_id;
    assign o_usbd_status       = r_usbd_status;
    assign o_function_code     = r_function_code;
    assign o_direction_info    = r_direction_info;
    assign o_bus_number        = r_bus_number;
    assign o_device_address    = r_device_address;
    assign o_endpoint_number   = r_endpoint_number;
    assign o_transfer_type     = r_transfer_type;
    assign o_data_length       = r_data_length;
    assign o_payload_clipped   = r_trunc;

endmodule

// ===== rtl/usb_capture_header_parser_core.sv =====
// Capture record header parser. Takes one byte of a capture record per clock, with
// i_last on the final byte, and returns one result per record: the fields of the
// 27-byte little-endian base header, a status code and a payload-clipped flag.
// Bytes of all records are accepted one per cycle back to back; the only stall on
// the input comes when the record queue (QUEUE_DEPTH records, default 2) is full
// because the result side is not draining. A record enters the queue on the edge that takes
// its last byte, then passes the stage 1 registers for the length arithmetic and compares,
// then the output register, which holds the status decision. The back end retires one
// record per cycle while i_out_ready does not stall it. Payload bytes are counted, not
// forwarded; the byte count saturates at 0xFFFFFFFF.
module usb_capture_header_parser_core #(
    parameter int unsigned QUEUE_DEPTH = usbchp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic        i_has_original_length,
    input  logic [31:0] i_original_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_hdr_len,
    output logic [63:0] o_irp_id,
    output logic [31:0] o_usbd_status,
    output logic [15:0] o_function_code,
    output logic        o_direction_info,
    output logic [15:0] o_bus_number,
    output logic [15:0] o_device_address,
    output logic [7:0]  o_endpoint_number,
    output logic [7:0]  o_transfer_type,
    output logic [31:0] o_data_length,
    output logic        o_payload_clipped
);
    import usbchp_pkg::*;

    logic push_valid;
    logic push_ready;
    t_rec push_rec;
    logic pop_valid;
    logic pop_ready;
    t_rec pop_rec;

    // Byte front end: count and capture
    usbchp_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_data_byte           (i_data_byte),
        .i_last                (i_last),
        .i_has_original_length (i_has_original_length),
        .i_original_length     (i_original_length),
        .o_push_valid          (push_valid),
        .o_push_rec            (push_rec),
        .i_push_ready          (push_ready)
    );

    // Finished records waiting for the checks
    usbchp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_rec   (push_rec),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_rec    (pop_rec)
    );

    // Check back end and result register
    usbchp_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_pop_valid         (pop_valid),
        .o_pop_ready         (pop_ready),
        .i_pop_rec           (pop_rec),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_hdr_len           (o_hdr_len),
        .o_irp_id            (o_irp_id),
        .o_usbd_status       (o_usbd_status),
        .o_function_code     (o_function_code),
        .o_direction_info    (o_direction_info),
        .o_bus_number        (o_bus_number),
        .o_device_address    (o_device_address),
        .o_endpoint_number   (o_endpoint_number),
        .o_transfer_type     (o_transfer_type),
        .o_data_length       (o_data_length),
        .o_payload_clipped   (o_payload_clipped)
    );

endmodule

// ===== rtl/usbchp_checker.sv =====
module usbchp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [15:0] o_hdr_len,
    input logic [63:0] o_irp_id,
    input logic [31:0] o_data_length,
    input logic        o_payload_clipped
);
    import usbchp_pkg::*;

    // A stalled result transaction holds its status
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result changed while stalled");

    // Short records report zeroed header fields
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_SHORT) |->
            (o_hdr_len == 16'd0) && (o_irp_id == 64'd0)
            && (o_data_length == 32'd0) && !o_payload_clipped)
        else $error("short record with nonzero fields");

    // Truncation flag only on an accepted record
    a_trunc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_clipped |-> o_status == ST_OK)
        else $error("truncation flag with error status");

    // An accepted record has a header length of at least the base header
    a_ok_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK) |->
            o_hdr_len >= 16'(BASE_HEADER_BYTES))
        else $error("ok status with short header length");

endmodule

bind usb_capture_header_parser_core usbchp_checker u_usbchp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_status            (o_status),
    .o_hdr_len           (o_hdr_len),
    .o_irp_id            (o_irp_id),
    .o_data_length       (o_data_length),
    .o_payload_clipped   (o_payload_clipped)
);
